>>> hdl/sch_pkg.sv
// Shared types and constants for the sphere contact heat conduction unit.
`default_nettype none

package sch_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ESHIFT     = 2 * FRAC_BITS - 2;
  localparam int SQRT_STEPS = 64;
  localparam int KDIV_STEPS = 31;
  localparam int RDIV_STEPS = 31;

  localparam logic [30:0] TIME_STEP_RESET = 31'd65;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DIST = 2'd1;
  localparam logic [1:0] STATUS_NO_ISECT  = 2'd2;

  localparam logic [63:0] ENERGY_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ENERGY_NEG_MAG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        [30:0] radius_a;
    logic        [30:0] radius_b;
    logic signed [31:0] overlap_depth;
    logic        [30:0] conductivity_a;
    logic        [30:0] conductivity_b;
    logic signed [31:0] temperature_a;
    logic signed [31:0] temperature_b;
  } contact_t;

  typedef struct packed {
    logic signed [63:0] energy_moved;
    logic        [30:0] contact_radius;
    logic        [1:0]  contact_status;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/sphere_contact_heat_conduction_unit.sv
// Sphere-sphere contact radius and conduction energy, fully pipelined.
//
// One contact request enters on contact/contact_valid and is taken at a clock
// edge where contact_valid is high and contact_stall is low. Its result leaves
// on result/result_valid and is taken where result_valid is high and
// result_stall is low. Exactly one result comes back per request, in order.
// The time step register is written with time_step_we/time_step_data.
//
// The path runs through the 64-stage square root of the 128-bit intersection
// product and the 31-stage divide by twice the center distance. Throughput is
// one request per cycle while the pipeline is not held by result_stall.
// The conductivity quotient runs in the first 31 square-root stages.
//
// Reset (rst, synchronous) empties the pipeline and loads the time step with
// its default. While result_valid is high and result_stall is high the whole
// pipeline holds, and contact_stall is raised for that cycle; no request is
// lost or repeated.
`default_nettype none

module sphere_contact_heat_conduction_unit
  import sch_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        time_step_we,
  input  logic [30:0] time_step_data,
  input  logic        contact_valid,
  output logic        contact_stall,
  input  contact_t    contact,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  typedef struct packed {
    logic [1:0]  status;
    logic        neg;
    logic [32:0] ad;
    logic [32:0] magt;
    logic [31:0] ksum;
    logic [61:0] kprod;
  } front_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        neg;
    logic [32:0] ad;
    logic [32:0] magt;
    logic [31:0] ksum;
    logic [31:0] krem;
    logic [30:0] kq;
  } sqrt_side_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        neg;
    logic [32:0] magt;
    logic [30:0] keff;
    logic [33:0] dvsr;
    logic        sat;
  } div_side_t;

  logic        en;
  logic [30:0] time_step;

  assign en            = !(result_valid && result_stall);
  assign contact_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
    end else if (time_step_we) begin
      time_step <= time_step_data;
    end
  end

  // front end: distance, extents, conductivity sum and product
  logic        v1, v2, v3, v4, v5, v6;
  logic [33:0] d1;
  logic [30:0] big1, small1;
  logic [32:0] dtemp1;
  logic [31:0] ksum1;
  logic [61:0] kprod1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= 34'(contact.radius_a) + 34'(contact.radius_b)
            - {{2{contact.overlap_depth[31]}}, contact.overlap_depth};
      if (contact.radius_a >= contact.radius_b) begin
        big1   <= contact.radius_a;
        small1 <= contact.radius_b;
      end else begin
        big1   <= contact.radius_b;
        small1 <= contact.radius_a;
      end
      dtemp1 <= {contact.temperature_a[31], contact.temperature_a}
                - {contact.temperature_b[31], contact.temperature_b};
      ksum1  <= 32'(contact.conductivity_a) + 32'(contact.conductivity_b);
      kprod1 <= 62'(contact.conductivity_a) * 62'(contact.conductivity_b);
    end
  end

  logic [32:0] ad2, magt2;
  logic [30:0] diff2;
  logic [31:0] sum2, ksum2;
  logic [61:0] kprod2;
  logic        dzero2, dneg2, tneg2;

  always_ff @(posedge clk) begin
    if (en) begin
      ad2    <= d1[33] ? 33'(34'(0) - d1) : d1[32:0];
      magt2  <= dtemp1[32] ? 33'(33'(0) - dtemp1) : dtemp1;
      diff2  <= big1 - small1;
      sum2   <= 32'(big1) + 32'(small1);
      dzero2 <= (d1 == '0);
      dneg2  <= d1[33];
      tneg2  <= dtemp1[32];
      ksum2  <= ksum1;
      kprod2 <= kprod1;
    end
  end

  front_t      f3;
  logic [32:0] a1_3, a2_3, b1_3;
  logic [33:0] b2_3;
  logic [1:0]  status_next;

  always_comb begin
    if (dzero2) begin
      status_next = STATUS_ZERO_DIST;
    end else if ((ad2 < 33'(diff2)) || (ad2 > 33'(sum2))) begin
      status_next = STATUS_NO_ISECT;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3.status <= status_next;
      f3.neg    <= dneg2 ^ tneg2;
      f3.ad     <= ad2;
      f3.magt   <= magt2;
      f3.ksum   <= ksum2;
      f3.kprod  <= kprod2;
      a1_3      <= ad2 - 33'(diff2);
      a2_3      <= ad2 + 33'(diff2);
      b1_3      <= 33'(sum2) - ad2;
      b2_3      <= 34'(sum2) + 34'(ad2);
    end
  end

  front_t      f4;
  logic [63:0] fa4, fb4;
  logic [65:0] fa_full;
  logic [66:0] fb_full;

  assign fa_full = 66'(a1_3) * 66'(a2_3);
  assign fb_full = 67'(b1_3) * 67'(b2_3);

  always_ff @(posedge clk) begin
    if (en) begin
      f4  <= f3;
      fa4 <= fa_full[63:0];
      fb4 <= fb_full[63:0];
    end
  end

  front_t      f5;
  logic [63:0] p00_5, p01_5, p10_5, p11_5;

  always_ff @(posedge clk) begin
    if (en) begin
      f5    <= f4;
      p00_5 <= 64'(fa4[31:0]) * 64'(fb4[31:0]);
      p01_5 <= 64'(fa4[31:0]) * 64'(fb4[63:32]);
      p10_5 <= 64'(fa4[63:32]) * 64'(fb4[31:0]);
      p11_5 <= 64'(fa4[63:32]) * 64'(fb4[63:32]);
    end
  end

  front_t      f6;
  logic [64:0] mid6;
  logic [63:0] p00_6, p11_6;

  always_ff @(posedge clk) begin
    if (en) begin
      f6    <= f5;
      mid6  <= 65'(p01_5) + 65'(p10_5);
      p00_6 <= p00_5;
      p11_6 <= p11_5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= contact_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // square root of the intersection product, one root bit per stage
  logic             sv    [0:SQRT_STEPS];
  logic [127:0]     sp    [0:SQRT_STEPS];
  logic [65:0]      srem  [0:SQRT_STEPS];
  logic [63:0]      sroot [0:SQRT_STEPS];
  sqrt_side_t       sm    [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sp[0]       <= {p11_6, p00_6} + {31'b0, mid6, 32'b0};
      srem[0]     <= '0;
      sroot[0]    <= '0;
      sm[0].status <= f6.status;
      sm[0].neg    <= f6.neg;
      sm[0].ad     <= f6.ad;
      sm[0].magt   <= f6.magt;
      sm[0].ksum   <= f6.ksum;
      sm[0].krem   <= {1'b0, f6.kprod[61:31]};
      sm[0].kq     <= f6.kprod[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= v6;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    logic [67:0] rem_x;
    logic [65:0] trial;
    logic        root_bit;
    sqrt_side_t  side_next;

    assign rem_x    = {srem[i], sp[i][127:126]};
    assign trial    = {sroot[i], 2'b01};
    assign root_bit = (rem_x >= {2'b00, trial});

    if (i < KDIV_STEPS) begin : g_kdiv
      logic [32:0] kt;
      logic        kge;

      assign kt  = {sm[i].krem, sm[i].kq[30]};
      assign kge = (kt >= {1'b0, sm[i].ksum});

      always_comb begin
        side_next      = sm[i];
        side_next.krem = kge ? 32'(kt - {1'b0, sm[i].ksum}) : kt[31:0];
        side_next.kq   = {sm[i].kq[29:0], kge};
      end
    end else begin : g_pass
      assign side_next = sm[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sp[i+1]    <= {sp[i][125:0], 2'b00};
        srem[i+1]  <= root_bit ? 66'(rem_x - {2'b00, trial}) : rem_x[65:0];
        sroot[i+1] <= {sroot[i][62:0], root_bit};
        sm[i+1]    <= side_next;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (en) begin
        sv[i+1] <= sv[i];
      end
    end
  end

  // divide the root by twice the distance, one quotient bit per stage
  logic        dv   [0:RDIV_STEPS];
  logic [33:0] drem [0:RDIV_STEPS];
  logic [30:0] dq   [0:RDIV_STEPS];
  div_side_t   ds   [0:RDIV_STEPS];
  logic [33:0] dvsr0;

  assign dvsr0 = {sm[SQRT_STEPS].ad, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0]      <= {1'b0, sroot[SQRT_STEPS][63:31]};
      dq[0]        <= sroot[SQRT_STEPS][30:0];
      ds[0].status <= sm[SQRT_STEPS].status;
      ds[0].neg    <= sm[SQRT_STEPS].neg;
      ds[0].magt   <= sm[SQRT_STEPS].magt;
      ds[0].keff   <= (sm[SQRT_STEPS].ksum == '0) ? '0 : sm[SQRT_STEPS].kq;
      ds[0].dvsr   <= dvsr0;
      ds[0].sat    <= ({1'b0, sroot[SQRT_STEPS][63:31]} >= dvsr0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[SQRT_STEPS];
    end
  end

  for (genvar i = 0; i < RDIV_STEPS; i++) begin : g_rdiv
    logic [34:0] t;
    logic        ge;

    assign t  = {drem[i], dq[i][30]};
    assign ge = (t >= {1'b0, ds[i].dvsr});

    always_ff @(posedge clk) begin
      if (en) begin
        drem[i+1] <= ge ? 34'(t - {1'b0, ds[i].dvsr}) : t[33:0];
        dq[i+1]   <= {dq[i][29:0], ge};
        ds[i+1]   <= ds[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (en) begin
        dv[i+1] <= dv[i];
      end
    end
  end

  // energy: rc*keff times dt*|dT|, split into partial products
  logic        fv1, fv2, fv3, fv4;
  logic [30:0] rc_sel;
  logic [30:0] rc1, rc2, rc3, rc4;
  logic [1:0]  st1, st2, st3, st4;
  logic        ng1, ng2, ng3, ng4;
  logic [61:0] ma1;
  logic [63:0] mb1;

  always_comb begin
    if (ds[RDIV_STEPS].status != STATUS_OK) begin
      rc_sel = '0;
    end else if (ds[RDIV_STEPS].sat) begin
      rc_sel = '1;
    end else begin
      rc_sel = dq[RDIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc1 <= rc_sel;
      st1 <= ds[RDIV_STEPS].status;
      ng1 <= ds[RDIV_STEPS].neg;
      ma1 <= 62'(rc_sel) * 62'(ds[RDIV_STEPS].keff);
      mb1 <= 64'(time_step) * 64'(ds[RDIV_STEPS].magt);
    end
  end

  logic [62:0] q00, q01, q10, q11;

  always_ff @(posedge clk) begin
    if (en) begin
      rc2 <= rc1;
      st2 <= st1;
      ng2 <= ng1;
      q00 <= 63'(ma1[30:0]) * 63'(mb1[31:0]);
      q01 <= 63'(ma1[30:0]) * 63'(mb1[63:32]);
      q10 <= 63'(ma1[61:31]) * 63'(mb1[31:0]);
      q11 <= 63'(ma1[61:31]) * 63'(mb1[63:32]);
    end
  end

  logic [94:0] lo3, hi3;

  always_ff @(posedge clk) begin
    if (en) begin
      rc3 <= rc2;
      st3 <= st2;
      ng3 <= ng2;
      lo3 <= 95'(q00) + {q01, 32'b0};
      hi3 <= 95'(q10) + {q11, 32'b0};
    end
  end

  logic [125:0] e4;

  always_ff @(posedge clk) begin
    if (en) begin
      rc4 <= rc3;
      st4 <= st3;
      ng4 <= ng3;
      e4  <= 126'(lo3) + {hi3, 31'b0};
    end
  end

  logic [125:0] es;
  logic         over;
  logic [63:0]  el, energy_next;

  assign es   = e4 >> ESHIFT;
  assign over = |es[125:64];
  assign el   = es[63:0];

  always_comb begin
    if (st4 != STATUS_OK) begin
      energy_next = '0;
    end else if (ng4) begin
      energy_next = 64'(0) - ((over || (el > ENERGY_NEG_MAG)) ? ENERGY_NEG_MAG : el);
    end else begin
      energy_next = (over || el[63]) ? ENERGY_POS_MAX : el;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.energy_moved   <= energy_next;
      result.contact_radius <= rc4;
      result.contact_status <= st4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv1          <= 1'b0;
      fv2          <= 1'b0;
      fv3          <= 1'b0;
      fv4          <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      fv1          <= dv[RDIV_STEPS];
      fv2          <= fv1;
      fv3          <= fv2;
      fv4          <= fv3;
      result_valid <= fv4;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sch_checker.sv
// Port-level checks for the sphere contact heat conduction unit, and its bind.
`default_nettype none

module sch_checker
  import sch_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    contact_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    contact_stall |-> result_valid && result_stall)
    else $error("request stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result after reset");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.contact_status != STATUS_OK |->
      result.energy_moved == '0 && result.contact_radius == '0)
    else $error("skipped contact carries nonzero result");

  a_radius_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.contact_radius == '0 |-> result.energy_moved == '0)
    else $error("energy without contact radius");

endmodule

bind sphere_contact_heat_conduction_unit sch_checker u_sch_checker (
  .clk           (clk),
  .rst           (rst),
  .contact_stall (contact_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result        (result)
);

`default_nettype wire
